// File: hdl/sorted_deadline_timer_queue_core_assert.svh
// Assertion macros for the timer queue RTL.
// No dependencies; included by the core, which checks its own logic.
`ifndef SORTED_DEADLINE_TIMER_QUEUE_CORE_ASSERT_SVH
`define SORTED_DEADLINE_TIMER_QUEUE_CORE_ASSERT_SVH

// Same-cycle implication under an active-low reset.
`define SDTQ_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under an active-low reset.
`define SDTQ_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/sdtq_pkg.sv
// Types and constants for the sorted deadline timer queue.
// No dependencies; used by the cell, the chain and the top level.
package sdtq_pkg;

    localparam logic [63:0] ALL_ONES = {64{1'b1}};
    localparam logic [31:0] TPS_RESET = 32'd10000000;
    localparam int MAX_RESULTS = 16;

    localparam logic CMD_ADD     = 1'b0;
    localparam logic CMD_EXPIRE  = 1'b1;
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic        command;
        logic [63:0] now_time;
        logic [15:0] event_tag;
        logic [31:0] wait_seconds;
    } in_item_t;

    typedef struct packed {
        logic        fired;
        logic [15:0] fired_tag;
        logic [63:0] next_compare;
        logic        compare_update;
        logic        status;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [63:0] deadline;
        logic [15:0] tag;
    } entry_t;

    typedef struct packed {
        logic   insert;
        logic   pop;
        entry_t entry;
    } chain_op_t;

endpackage

// File: hdl/sorted_deadline_timer_queue_core.sv
// Sorted deadline timer queue: an add goes through states MUL, ADD and INS (multiply,
// saturating add, insertion into the cell row); no new item is taken until it is done.
// An expire presents its results from state EXP, one per cycle while the output is not stalled,
// up to 16; the input is held off until the last one. Output stalls also hold an add in INS.
// The 32x32 multiplier, the 64-bit add and the per-cell deadline compare each have their own state.
// Reset is synchronous, active low: the queue empties and ticks_per_second returns to 10000000.
// Depends on sdtq_pkg, sdtq_chain and the assertion macro header.
`include "sorted_deadline_timer_queue_core_assert.svh"

module sorted_deadline_timer_queue_core #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [31:0]         cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  sdtq_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output sdtq_pkg::out_item_t m_data
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int POP_W = $clog2(sdtq_pkg::MAX_RESULTS);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_ADD  = 3'd2;
    localparam logic [2:0] ST_INS  = 3'd3;
    localparam logic [2:0] ST_EXP  = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [POP_W-1:0]    pop_cnt_reg, pop_cnt_next;
    logic [31:0]         tps_reg;
    sdtq_pkg::in_item_t  in_reg;
    logic [63:0]         prod_reg;
    logic [63:0]         deadline_reg;
    logic                m_valid_reg, m_valid_next;
    sdtq_pkg::out_item_t m_data_reg, m_data_next;

    sdtq_pkg::chain_op_t op;
    sdtq_pkg::entry_t    head_entry;
    sdtq_pkg::entry_t    second_entry;
    logic                head_keep;

    logic        accept;
    logic        out_free;
    logic        is_full;
    logic        due;
    logic        more;
    logic [63:0] cur_head;
    logic [63:0] after_pop;
    logic [64:0] sum;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    assign is_full   = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign cur_head  = (count_reg != '0) ? head_entry.deadline : sdtq_pkg::ALL_ONES;
    assign after_pop = (count_reg > CNT_W'(1)) ? second_entry.deadline : sdtq_pkg::ALL_ONES;
    assign due       = (count_reg != '0) && (head_entry.deadline <= in_reg.now_time);
    assign more      = (pop_cnt_reg != POP_W'(sdtq_pkg::MAX_RESULTS - 1))
                       && (count_reg > CNT_W'(1))
                       && (second_entry.deadline <= in_reg.now_time);
    assign sum       = {1'b0, in_reg.now_time} + {1'b0, prod_reg};

    assign op.insert         = (state_reg == ST_INS) && out_free && !is_full;
    assign op.pop            = (state_reg == ST_EXP) && out_free && due;
    assign op.entry.deadline = deadline_reg;
    assign op.entry.tag      = in_reg.event_tag;

    sdtq_chain #(
        .DEPTH (QUEUE_DEPTH)
    ) u_chain (
        .aclk         (aclk),
        .op           (op),
        .count        (count_reg),
        .head_entry   (head_entry),
        .second_entry (second_entry),
        .head_keep    (head_keep)
    );

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        pop_cnt_next = pop_cnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    pop_cnt_next = '0;
                    state_next   = (s_data.command == sdtq_pkg::CMD_EXPIRE) ? ST_EXP : ST_MUL;
                end
            end
            ST_MUL: begin
                state_next = ST_ADD;
            end
            ST_ADD: begin
                state_next = ST_INS;
            end
            ST_INS: begin
                if (out_free) begin
                    m_valid_next               = 1'b1;
                    m_data_next.fired          = 1'b0;
                    m_data_next.fired_tag      = '0;
                    m_data_next.last           = 1'b1;
                    if (is_full) begin
                        m_data_next.next_compare   = cur_head;
                        m_data_next.compare_update = 1'b0;
                        m_data_next.status         = sdtq_pkg::STATUS_FULL;
                    end else begin
                        m_data_next.next_compare   = head_keep ? head_entry.deadline
                                                               : deadline_reg;
                        m_data_next.compare_update = !head_keep;
                        m_data_next.status         = sdtq_pkg::STATUS_OK;
                        count_next                 = count_reg + CNT_W'(1);
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_EXP: begin
                if (out_free) begin
                    m_valid_next       = 1'b1;
                    m_data_next.status = sdtq_pkg::STATUS_OK;
                    if (due) begin
                        m_data_next.fired          = 1'b1;
                        m_data_next.fired_tag      = head_entry.tag;
                        m_data_next.next_compare   = after_pop;
                        m_data_next.compare_update = !more;
                        m_data_next.last           = !more;
                        count_next                 = count_reg - CNT_W'(1);
                        pop_cnt_next               = pop_cnt_reg + POP_W'(1);
                        if (!more) begin
                            state_next = ST_IDLE;
                        end
                    end else begin
                        m_data_next.fired          = 1'b0;
                        m_data_next.fired_tag      = '0;
                        m_data_next.next_compare   = cur_head;
                        m_data_next.compare_update = 1'b1;
                        m_data_next.last           = 1'b1;
                        state_next                 = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            pop_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
            tps_reg     <= sdtq_pkg::TPS_RESET;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            pop_cnt_reg <= pop_cnt_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                tps_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            in_reg <= s_data;
        end
        prod_reg     <= 64'(in_reg.wait_seconds) * 64'(tps_reg);
        deadline_reg <= sum[64] ? sdtq_pkg::ALL_ONES : sum[63:0];
        m_data_reg   <= m_data_next;
    end

    `SDTQ_ASSERT_NOW(a_count_range, aclk, aresetn, 1'b1, count_reg <= CNT_W'(QUEUE_DEPTH), "count over depth")
    `SDTQ_ASSERT_NOW(a_fired_ok, aclk, aresetn, m_valid && m_data.fired, !m_data.status, "fired with status")
    `SDTQ_ASSERT_NEXT(a_pop_count, aclk, aresetn, op.pop, count_reg == $past(count_reg) - CNT_W'(1), "pop miscount")
    `SDTQ_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, accept, !s_ready, "ready while busy")

endmodule

// File: hdl/sdtq_cell.sv
// One queue cell: holds an entry and shifts it toward either neighbor.
// Depends on sdtq_pkg.
module sdtq_cell (
    input  logic               aclk,
    input  sdtq_pkg::chain_op_t op,
    input  logic               occupied,
    input  logic               left_keep,
    input  sdtq_pkg::entry_t   left_entry,
    input  sdtq_pkg::entry_t   right_entry,
    output sdtq_pkg::entry_t   entry,
    output logic               keep
);

    sdtq_pkg::entry_t entry_reg;
    sdtq_pkg::entry_t entry_next;

    // An occupied cell whose deadline is not later than the new one stays put.
    assign keep  = occupied && (entry_reg.deadline <= op.entry.deadline);
    assign entry = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        if (op.insert && !keep) begin
            entry_next = left_keep ? op.entry : left_entry;
        end else if (op.pop) begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

// File: hdl/sdtq_chain.sv
// Row of queue cells kept in ascending deadline order, head at cell zero.
// Depends on sdtq_pkg and sdtq_cell.
module sdtq_chain #(
    parameter int DEPTH = 16
) (
    input  logic                         aclk,
    input  sdtq_pkg::chain_op_t          op,
    input  logic [$clog2(DEPTH+1)-1:0]   count,
    output sdtq_pkg::entry_t             head_entry,
    output sdtq_pkg::entry_t             second_entry,
    output logic                         head_keep
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    sdtq_pkg::entry_t entries [DEPTH];
    logic             keeps   [DEPTH];

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        sdtq_pkg::entry_t left_entry;
        sdtq_pkg::entry_t right_entry;
        logic             left_keep;

        if (i == 0) begin : g_first
            assign left_entry = op.entry;
            assign left_keep  = 1'b1;
        end else begin : g_mid
            assign left_entry = entries[i-1];
            assign left_keep  = keeps[i-1];
        end

        if (i == DEPTH - 1) begin : g_end
            assign right_entry = entries[i];
        end else begin : g_inner
            assign right_entry = entries[i+1];
        end

        sdtq_cell u_cell (
            .aclk        (aclk),
            .op          (op),
            .occupied    (count > CNT_W'(i)),
            .left_keep   (left_keep),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .entry       (entries[i]),
            .keep        (keeps[i])
        );
    end

    assign head_entry   = entries[0];
    assign second_entry = entries[1];
    assign head_keep    = keeps[0];

endmodule
